// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the core RTL.
// The checks compile only in simulation; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/s2g_pkg.sv =====
package s2g_pkg;

  localparam logic [11:0] SH_YEAR_MIN = 12'd979;
  localparam logic [11:0] SH_YEAR_MAX = 12'd2999;
  localparam logic [3:0]  SH_MONTH_MAX = 4'd12;
  localparam logic [11:0] GREG_YEAR_BASE = 12'd1600;
  localparam logic [19:0] DAYS_400Y = 20'd146097;
  localparam logic [19:0] DAYS_100Y = 20'd36524;
  localparam logic [19:0] DAYS_100Y_FIRST = 20'd36525;
  localparam logic [19:0] DAYS_4Y = 20'd1461;
  localparam logic [19:0] DAYS_1Y = 20'd365;
  localparam logic [19:0] DAYS_LEAP_1Y = 20'd366;

  // Datapath operations, one per controller step.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_Q33,
    OP_DAYS,
    OP_Q400,
    OP_R400,
    OP_C100,
    OP_Q100,
    OP_R100,
    OP_A100,
    OP_Q4,
    OP_R4,
    OP_C1,
    OP_Q1,
    OP_R1,
    OP_MONTH,
    OP_ZQ,
    OP_ZR,
    OP_ZS,
    OP_Z7Q,
    OP_Z7R
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_Q33,
    ST_DAYS,
    ST_Q400,
    ST_R400,
    ST_C100,
    ST_Q100,
    ST_R100,
    ST_A100,
    ST_Q4,
    ST_R4,
    ST_C1,
    ST_Q1,
    ST_R1,
    ST_MONTH,
    ST_ZQ,
    ST_ZR,
    ST_ZS,
    ST_Z7Q,
    ST_Z7R,
    ST_OUT
  } ctl_state_t;

  // Days before the first of a Shamsi month; month zero counts as month one.
  function automatic logic [8:0] shamsi_prefix(input logic [3:0] m);
    logic [8:0] v;
    case (m) inside
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd62;
      4'd4:       v = 9'd93;
      4'd5:       v = 9'd124;
      4'd6:       v = 9'd155;
      4'd7:       v = 9'd186;
      4'd8:       v = 9'd216;
      4'd9:       v = 9'd246;
      4'd10:      v = 9'd276;
      4'd11:      v = 9'd306;
      default:    v = 9'd336;
    endcase
    return v;
  endfunction

  // Day of year on which Gregorian month idx+1 starts.
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] v;
    case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

  // Month term of Zeller's congruence, with January and February
  // counted as months 13 and 14 of the previous year.
  function automatic logic [5:0] zeller_term(input logic [3:0] gm);
    logic [5:0] v;
    case (gm)
      4'd1:    v = 6'd36;
      4'd2:    v = 6'd39;
      4'd3:    v = 6'd10;
      4'd4:    v = 6'd13;
      4'd5:    v = 6'd15;
      4'd6:    v = 6'd18;
      4'd7:    v = 6'd20;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd26;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd31;
      4'd12:   v = 6'd33;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/shamsi_to_gregorian_weekday_core.sv =====
// A date transferred at one clock edge is worked through states Q33 to Z7R; its result strobe is in ST_OUT.
// A new date is taken only when the controller is idle; it walks a fixed 19-step sequence.
// Most steps use one multiply by a constant reciprocal or one compare-and-subtract.
// Reset (rst_n low, synchronous) returns the controller to idle; no result is pending.
// The receiver cannot stall: out_valid stands for exactly one cycle per result.
module shamsi_to_gregorian_weekday_core import s2g_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_shamsi_year,
  input  logic [3:0]  in_shamsi_month,
  input  logic [4:0]  in_shamsi_day,
  output logic        out_valid,
  output logic [11:0] out_greg_year,
  output logic [3:0]  out_greg_month,
  output logic [4:0]  out_greg_day,
  output logic [2:0]  out_week_day
);

  // The controller issues one datapath operation per cycle. A transfer on
  // the input side happens when start is high while busy is low; in that
  // cycle the datapath captures the date, with year and month clamped.
  dp_op_t op;

  s2g_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .op        (op)
  );

  // The datapath forms a day count from the 33-year cycle, splits it over
  // the Gregorian 400, 100, 4 and 1 year cycles, finds the month, and then
  // evaluates Zeller's congruence for the weekday. The result registers hold
  // their values until the next date overwrites them, so the outputs are
  // stable in the strobe cycle.
  s2g_dpath u_dpath (
    .clk             (clk),
    .op              (op),
    .in_shamsi_year  (in_shamsi_year),
    .in_shamsi_month (in_shamsi_month),
    .in_shamsi_day   (in_shamsi_day),
    .out_greg_year   (out_greg_year),
    .out_greg_month  (out_greg_month),
    .out_greg_day    (out_greg_day),
    .out_week_day    (out_week_day)
  );

endmodule

// ===== rtl/core/s2g_ctrl.sv =====
`include "assert_macros.svh"

module s2g_ctrl import s2g_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  output logic   out_valid,
  output dp_op_t op
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:  state_nxt = start ? ST_Q33 : ST_IDLE;
      ST_Q33:   state_nxt = ST_DAYS;
      ST_DAYS:  state_nxt = ST_Q400;
      ST_Q400:  state_nxt = ST_R400;
      ST_R400:  state_nxt = ST_C100;
      ST_C100:  state_nxt = ST_Q100;
      ST_Q100:  state_nxt = ST_R100;
      ST_R100:  state_nxt = ST_A100;
      ST_A100:  state_nxt = ST_Q4;
      ST_Q4:    state_nxt = ST_R4;
      ST_R4:    state_nxt = ST_C1;
      ST_C1:    state_nxt = ST_Q1;
      ST_Q1:    state_nxt = ST_R1;
      ST_R1:    state_nxt = ST_MONTH;
      ST_MONTH: state_nxt = ST_ZQ;
      ST_ZQ:    state_nxt = ST_ZR;
      ST_ZR:    state_nxt = ST_ZS;
      ST_ZS:    state_nxt = ST_Z7Q;
      ST_Z7Q:   state_nxt = ST_Z7R;
      ST_Z7R:   state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE:  op = start ? OP_LOAD : OP_NONE;
      ST_Q33:   op = OP_Q33;
      ST_DAYS:  op = OP_DAYS;
      ST_Q400:  op = OP_Q400;
      ST_R400:  op = OP_R400;
      ST_C100:  op = OP_C100;
      ST_Q100:  op = OP_Q100;
      ST_R100:  op = OP_R100;
      ST_A100:  op = OP_A100;
      ST_Q4:    op = OP_Q4;
      ST_R4:    op = OP_R4;
      ST_C1:    op = OP_C1;
      ST_Q1:    op = OP_Q1;
      ST_R1:    op = OP_R1;
      ST_MONTH: op = OP_MONTH;
      ST_ZQ:    op = OP_ZQ;
      ST_ZR:    op = OP_ZR;
      ST_ZS:    op = OP_ZS;
      ST_Z7Q:   op = OP_Z7Q;
      ST_Z7R:   op = OP_Z7R;
      default:  op = OP_NONE;
    endcase
  end

  `ASSERT_RST(a_strobe_single, clk, rst_n, out_valid |=> !out_valid, "result strobe held")
  `ASSERT_RST(a_start_busy, clk, rst_n, (start && !busy) |=> (busy && !out_valid), "no busy")
  `ASSERT_RST(a_done_idle, clk, rst_n, out_valid |=> !busy, "not idle after result")
  `ASSERT_RST(a_load_accept, clk, rst_n, (op == OP_LOAD) |-> (start && !busy), "bad load")

endmodule

// ===== rtl/core/s2g_dpath.sv =====
module s2g_dpath import s2g_pkg::*; (
  input  logic        clk,
  input  dp_op_t      op,
  input  logic [11:0] in_shamsi_year,
  input  logic [3:0]  in_shamsi_month,
  input  logic [4:0]  in_shamsi_day,
  output logic [11:0] out_greg_year,
  output logic [3:0]  out_greg_month,
  output logic [4:0]  out_greg_day,
  output logic [2:0]  out_week_day
);

  logic [10:0] yo_r, yo_nxt;
  logic [3:0]  sm_r, sm_nxt;
  logic [4:0]  sd_r, sd_nxt;
  logic [5:0]  q_r, q_nxt;
  logic [19:0] n_r, n_nxt;
  logic [11:0] gy_r, gy_nxt;
  logic        leap_r, leap_nxt;
  logic        flag_r, flag_nxt;
  logic [3:0]  gm_r, gm_nxt;
  logic [4:0]  gd_r, gd_nxt;
  logic [6:0]  zk_r, zk_nxt;
  logic [5:0]  zc_r, zc_nxt;
  logic [8:0]  zs_r, zs_nxt;
  logic [2:0]  wd_r, wd_nxt;

  logic [11:0] sy_clamp;
  logic [21:0] prod33;
  logic [10:0] q33_x33;
  logic [5:0]  r33;
  logic [22:0] prod400;
  logic [19:0] prod100;
  logic [20:0] prod4;
  logic [12:0] prod1;
  logic [19:0] sub_big;
  logic [19:0] rem_big;
  logic        fix_big;
  logic [11:0] zy;
  logic [17:0] prodz;
  logic [11:0] zrem;
  logic [14:0] prod7;
  logic [8:0]  rem7;
  logic [8:0]  nm;
  logic [3:0]  mcnt;

  always_ff @(posedge clk) begin
    yo_r   <= yo_nxt;
    sm_r   <= sm_nxt;
    sd_r   <= sd_nxt;
    q_r    <= q_nxt;
    n_r    <= n_nxt;
    gy_r   <= gy_nxt;
    leap_r <= leap_nxt;
    flag_r <= flag_nxt;
    gm_r   <= gm_nxt;
    gd_r   <= gd_nxt;
    zk_r   <= zk_nxt;
    zc_r   <= zc_nxt;
    zs_r   <= zs_nxt;
    wd_r   <= wd_nxt;
  end

  // Shared helpers; each is only meaningful in the step that uses it.
  always_comb begin
    if (in_shamsi_year < SH_YEAR_MIN) begin
      sy_clamp = SH_YEAR_MIN;
    end else if (in_shamsi_year > SH_YEAR_MAX) begin
      sy_clamp = SH_YEAR_MAX;
    end else begin
      sy_clamp = in_shamsi_year;
    end
    prod33  = 22'(yo_r) * 22'd1986;
    q33_x33 = 11'(q_r) * 11'd33;
    r33     = 6'(yo_r - q33_x33);
    prod400 = 23'(n_r) * 23'd7;
    prod100 = n_r * 20'd7;
    prod4   = 21'(n_r) * 21'd44;
    prod1   = 13'(n_r) * 13'd5;
    zy      = (gm_r < 4'd3) ? (gy_r - 12'd1) : gy_r;
    prodz   = 18'(zy) * 18'd40;
    zrem    = zy - (12'(q_r) * 12'd100);
    prod7   = 15'(zs_r) * 15'd73;
    rem7    = zs_r - (9'(q_r) * 9'd7);
    nm      = n_r[8:0];
  end

  // Remainder against the divisor of the current step.
  always_comb begin
    case (op)
      OP_R400: sub_big = 20'(q_r[2:0]) * DAYS_400Y;
      OP_R100: sub_big = 20'(q_r[1:0]) * DAYS_100Y;
      OP_R4:   sub_big = 20'(q_r[4:0]) * DAYS_4Y;
      default: sub_big = 20'(q_r[1:0]) * DAYS_1Y;
    endcase
    rem_big = n_r - sub_big;
    case (op)
      OP_R400: fix_big = (rem_big >= DAYS_400Y);
      OP_R100: fix_big = (rem_big >= DAYS_100Y);
      OP_R4:   fix_big = (rem_big >= DAYS_4Y);
      default: fix_big = (rem_big >= DAYS_1Y);
    endcase
  end

  // Month search: the count of month starts at or below the day of year.
  always_comb begin
    mcnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (nm >= month_start(4'(k), leap_r)) begin
        mcnt = mcnt + 4'd1;
      end
    end
  end

  always_comb begin
    yo_nxt   = yo_r;
    sm_nxt   = sm_r;
    sd_nxt   = sd_r;
    q_nxt    = q_r;
    n_nxt    = n_r;
    gy_nxt   = gy_r;
    leap_nxt = leap_r;
    flag_nxt = flag_r;
    gm_nxt   = gm_r;
    gd_nxt   = gd_r;
    zk_nxt   = zk_r;
    zc_nxt   = zc_r;
    zs_nxt   = zs_r;
    wd_nxt   = wd_r;
    unique case (op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        yo_nxt = 11'(sy_clamp - SH_YEAR_MIN);
        sm_nxt = (in_shamsi_month > SH_MONTH_MAX) ? SH_MONTH_MAX : in_shamsi_month;
        sd_nxt = in_shamsi_day;
      end
      OP_Q33: begin
        q_nxt = prod33[21:16];
      end
      OP_DAYS: begin
        n_nxt = 20'(yo_r) * DAYS_1Y + 20'({q_r, 3'b000})
              + 20'((7'(r33) + 7'd3) >> 2) + 20'(shamsi_prefix(sm_r))
              + 20'(sd_r) + 20'd78;
        gy_nxt   = GREG_YEAR_BASE;
        leap_nxt = 1'b1;
      end
      OP_Q400: begin
        q_nxt = 6'(prod400[22:20]);
      end
      OP_R400: begin
        n_nxt  = fix_big ? (rem_big - DAYS_400Y) : rem_big;
        gy_nxt = gy_r + 12'(3'(q_r[2:0]) + 3'(fix_big)) * 12'd400;
      end
      OP_C100: begin
        flag_nxt = (n_r >= DAYS_100Y_FIRST);
        if (n_r >= DAYS_100Y_FIRST) begin
          n_nxt = n_r - 20'd1;
        end
      end
      OP_Q100: begin
        q_nxt = flag_r ? 6'(prod100[19:18]) : 6'd0;
      end
      OP_R100: begin
        if (flag_r) begin
          n_nxt  = fix_big ? (rem_big - DAYS_100Y) : rem_big;
          gy_nxt = gy_r + 12'(3'(q_r[1:0]) + 3'(fix_big)) * 12'd100;
        end
      end
      OP_A100: begin
        if (flag_r) begin
          if (n_r >= DAYS_1Y) begin
            n_nxt = n_r + 20'd1;
          end else begin
            leap_nxt = 1'b0;
          end
        end
      end
      OP_Q4: begin
        q_nxt = 6'(prod4[20:16]);
      end
      OP_R4: begin
        n_nxt  = fix_big ? (rem_big - DAYS_4Y) : rem_big;
        gy_nxt = gy_r + (12'(5'(q_r[4:0]) + 5'(fix_big)) << 2);
      end
      OP_C1: begin
        flag_nxt = (n_r >= DAYS_LEAP_1Y);
        if (n_r >= DAYS_LEAP_1Y) begin
          leap_nxt = 1'b0;
          n_nxt    = n_r - 20'd1;
        end
      end
      OP_Q1: begin
        q_nxt = flag_r ? 6'(prod1[12:11]) : 6'd0;
      end
      OP_R1: begin
        if (flag_r) begin
          n_nxt  = fix_big ? (rem_big - DAYS_1Y) : rem_big;
          gy_nxt = gy_r + 12'(3'(q_r[1:0]) + 3'(fix_big));
        end
      end
      OP_MONTH: begin
        gm_nxt = mcnt + 4'd1;
        gd_nxt = 5'(nm - month_start(mcnt, leap_r) + 9'd1);
      end
      OP_ZQ: begin
        q_nxt = prodz[17:12];
      end
      OP_ZR: begin
        zk_nxt = (zrem >= 12'd100) ? 7'(zrem - 12'd100) : 7'(zrem);
        zc_nxt = q_r + 6'(zrem >= 12'd100);
      end
      OP_ZS: begin
        // Adding 77 keeps the sum positive without changing it modulo 7.
        zs_nxt = 9'(gd_r) + 9'(zeller_term(gm_r)) + 9'(zk_r) + 9'(zk_r >> 2)
               + 9'(zc_r >> 2) + 9'd77 - 9'({zc_r, 1'b0});
      end
      OP_Z7Q: begin
        q_nxt = prod7[14:9];
      end
      OP_Z7R: begin
        wd_nxt = (rem7 >= 9'd7) ? 3'(rem7 - 9'd7) : 3'(rem7);
      end
      default: begin
      end
    endcase
  end

  assign out_greg_year  = gy_r;
  assign out_greg_month = gm_r;
  assign out_greg_day   = gd_r;
  assign out_week_day   = wd_r;

endmodule

// ===== sim/s2g_date_checker.sv =====
module s2g_date_checker import s2g_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] in_shamsi_year,
  input  logic [3:0]  in_shamsi_month,
  input  logic [4:0]  in_shamsi_day,
  input  logic        out_valid,
  input  logic [11:0] out_greg_year,
  input  logic [3:0]  out_greg_month,
  input  logic [4:0]  out_greg_day,
  input  logic [2:0]  out_week_day,
  output int          fail_count,
  output int          outstanding,
  output int          checked
);

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
  } greg_date_t;

  // A Gregorian date still to come, with the Shamsi date it was made from.
  typedef struct packed {
    logic [11:0] sh_year;
    logic [3:0]  sh_month;
    logic [4:0]  sh_day;
    greg_date_t  greg;
  } pending_date_t;

  pending_date_t expected_dates[$];
  int errs;
  int n_checked;

  function automatic greg_date_t shamsi_to_greg(input logic [11:0] sy_in,
                                                input logic [3:0]  sm_in,
                                                input logic [4:0]  sd_in);
    int sy, sm, yo, n, gy, gm, i, mlen, zy, zm, k, c, h;
    logic leap, done;
    greg_date_t r;
    sy = int'(sy_in);
    sm = int'(sm_in);
    if (sy < int'(SH_YEAR_MIN)) sy = int'(SH_YEAR_MIN);
    if (sy > int'(SH_YEAR_MAX)) sy = int'(SH_YEAR_MAX);
    if (sm > int'(SH_MONTH_MAX)) sm = int'(SH_MONTH_MAX);

    // Day count from the first day of the base Shamsi year, 33-year cycle rule.
    yo = sy - int'(SH_YEAR_MIN);
    n = 365 * yo + (yo / 33) * 8 + (yo % 33 + 3) / 4;
    for (i = 0; i < sm - 1; i++) begin
      n += (i < 6) ? 31 : ((i < 11) ? 30 : 29);
    end
    n += int'(sd_in) - 1;
    n += 79;

    gy = int'(GREG_YEAR_BASE) + 400 * (n / 146097);
    n = n % 146097;
    leap = 1'b1;
    if (n >= 36525) begin
      n -= 1;
      gy += 100 * (n / 36524);
      n = n % 36524;
      if (n >= 365) begin
        n += 1;
      end else begin
        leap = 1'b0;
      end
    end
    gy += 4 * (n / 1461);
    n = n % 1461;
    if (n >= 366) begin
      leap = 1'b0;
      n -= 1;
      gy += n / 365;
      n = n % 365;
    end

    i = 0;
    done = 1'b0;
    while (!done && i < 11) begin
      if (i == 1) begin
        mlen = leap ? 29 : 28;
      end else if (i == 3 || i == 5 || i == 8 || i == 10) begin
        mlen = 30;
      end else begin
        mlen = 31;
      end
      if (n < mlen) begin
        done = 1'b1;
      end else begin
        n -= mlen;
        i++;
      end
    end
    gm = i + 1;

    // Zeller's congruence, with January and February moved to the year before.
    zy = gy;
    zm = gm;
    if (zm < 3) begin
      zm += 12;
      zy -= 1;
    end
    k = zy % 100;
    c = zy / 100;
    h = ((n + 1) + (13 * (zm + 1)) / 5 + k + k / 4 + c / 4 - 2 * c) % 7;
    if (h < 0) h += 7;

    r.year  = gy[11:0];
    r.month = gm[3:0];
    r.day   = n[4:0] + 5'd1;
    r.wday  = h[2:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [11:0] exp_v,
                             input logic [11:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : watch
    pending_date_t e;
    if (rst_n) begin
      if (start && !busy) begin
        e.sh_year  = in_shamsi_year;
        e.sh_month = in_shamsi_month;
        e.sh_day   = in_shamsi_day;
        e.greg     = shamsi_to_greg(in_shamsi_year, in_shamsi_month, in_shamsi_day);
        expected_dates.push_back(e);
      end
      if (out_valid) begin
        if (expected_dates.size() == 0) begin
          errs++;
          $display("%0t: result %0d-%0d-%0d day %0d with no date outstanding",
                   $time, out_greg_year, out_greg_month, out_greg_day, out_week_day);
        end else begin
          e = expected_dates.pop_front();
          if (out_greg_year !== e.greg.year || out_greg_month !== e.greg.month ||
              out_greg_day !== e.greg.day || out_week_day !== e.greg.wday) begin
            $display("%0t: wrong conversion of Shamsi %0d/%0d/%0d", $time,
                     e.sh_year, e.sh_month, e.sh_day);
          end
          check_field("year", e.greg.year, out_greg_year);
          check_field("month", 12'(e.greg.month), 12'(out_greg_month));
          check_field("day", 12'(e.greg.day), 12'(out_greg_day));
          check_field("weekday", 12'(e.greg.wday), 12'(out_week_day));
          n_checked++;
        end
      end
    end
    fail_count  <= errs;
    outstanding <= expected_dates.size();
    checked     <= n_checked;
  end

endmodule

// ===== sim/shamsi_to_gregorian_weekday_core_test.sv =====
module shamsi_to_gregorian_weekday_core_test;
  import s2g_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [11:0] in_shamsi_year;
  logic [3:0]  in_shamsi_month;
  logic [4:0]  in_shamsi_day;
  logic        out_valid;
  logic [11:0] out_greg_year;
  logic [3:0]  out_greg_month;
  logic [4:0]  out_greg_day;
  logic [2:0]  out_week_day;

  int fail_count;
  int outstanding;
  int checked;

  // Bookkeeping for the summary line only; it plays no part in the verdict.
  int dates_sent;
  int odd_dates_sent;

  // While set, the sender offers the next date at once, with no idle cycles.
  bit back_to_back;

  shamsi_to_gregorian_weekday_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_shamsi_year  (in_shamsi_year),
    .in_shamsi_month (in_shamsi_month),
    .in_shamsi_day   (in_shamsi_day),
    .out_valid       (out_valid),
    .out_greg_year   (out_greg_year),
    .out_greg_month  (out_greg_month),
    .out_greg_day    (out_greg_day),
    .out_week_day    (out_week_day)
  );

  // The checker sees the same pins as the block. It predicts every accepted
  // date and compares each result strobe against the oldest prediction.
  s2g_date_checker u_date_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_shamsi_year  (in_shamsi_year),
    .in_shamsi_month (in_shamsi_month),
    .in_shamsi_day   (in_shamsi_day),
    .out_valid       (out_valid),
    .out_greg_year   (out_greg_year),
    .out_greg_month  (out_greg_month),
    .out_greg_day    (out_greg_day),
    .out_week_day    (out_week_day),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .checked         (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one Shamsi date and returns at the clock edge where the transfer
  // happens. Start is lowered only when an idle gap follows, so a start that
  // stays high for back-to-back dates never sees two updates in one step.
  task automatic send_date(input logic [11:0] y, input logic [3:0] m,
                           input logic [4:0] d);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_shamsi_year  <= y;
    in_shamsi_month <= m;
    in_shamsi_day   <= d;
    // The block takes the date at the first edge where it is not busy.
    @(posedge clk);
    while (busy) @(posedge clk);
    dates_sent++;
    if (y < SH_YEAR_MIN || y > SH_YEAR_MAX || m == 4'd0 || m > SH_MONTH_MAX || d == 5'd0) begin
      odd_dates_sent++;
    end
  endtask

  initial begin
    int i;
    int wait_cycles;
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_shamsi_year  = '0;
    in_shamsi_month = '0;
    in_shamsi_day   = '0;
    back_to_back    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed dates. The first ones cover the ends of the year range and the
    // clamping on both sides of it, including all-zero and all-one fields.
    send_date(12'd979, 4'd1, 5'd1);
    send_date(12'd979, 4'd1, 5'd0);
    send_date(12'd2999, 4'd12, 5'd29);
    send_date(12'd0, 4'd0, 5'd0);
    send_date(12'd978, 4'd6, 5'd15);
    send_date(12'd3000, 4'd1, 5'd1);
    send_date(12'd4095, 4'd15, 5'd31);
    // Dates near late February of the century years 1700, 1800, 1900 and
    // 2000, where the leap rule for the 100- and 400-year cycles decides.
    send_date(12'd1078, 4'd12, 5'd10);
    send_date(12'd1178, 4'd12, 5'd10);
    send_date(12'd1278, 4'd12, 5'd10);
    send_date(12'd1378, 4'd12, 5'd10);
    send_date(12'd1378, 4'd12, 5'd11);
    // New year and the edges of the 31-, 30- and 29-day months.
    send_date(12'd1399, 4'd12, 5'd30);
    send_date(12'd1400, 4'd1, 5'd1);
    send_date(12'd1403, 4'd6, 5'd31);
    send_date(12'd1402, 4'd7, 5'd1);
    // A month of zero counts like the first month; months past twelve clamp.
    send_date(12'd1403, 4'd0, 5'd5);
    send_date(12'd1403, 4'd13, 5'd1);
    send_date(12'd1403, 4'd15, 5'd20);
    // A day of zero falls on the day before; days past the month run on.
    send_date(12'd1403, 4'd1, 5'd0);
    send_date(12'd1403, 4'd11, 5'd31);
    send_date(12'd1403, 4'd12, 5'd31);
    send_date(12'd1011, 4'd10, 5'd10);

    // Random dates. Most are inside the calendar range; one in five uses raw
    // field values so every bit of every field toggles. One stretch in four
    // runs with no idle cycles between dates.
    for (i = 0; i < 750; i++) begin
      back_to_back = ((i / 60) % 4) == 3;
      if ($urandom_range(0, 4) == 0) begin
        y = 12'($urandom);
        m = 4'($urandom);
        d = 5'($urandom);
      end else begin
        y = 12'($urandom_range(979, 2999));
        m = 4'($urandom_range(1, 12));
        d = 5'($urandom_range(1, 31));
      end
      send_date(y, m, d);
    end
    start <= 1'b0;

    // Drain: wait for every predicted date to come back, then a little more
    // than the block's latency so a stray extra strobe would be seen.
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (outstanding != 0 && wait_cycles < 400);
    repeat (25) @(posedge clk);

    if (outstanding != 0) begin
      $display("%0d converted dates never came back", outstanding);
    end
    $display("Sent %0d Shamsi dates, %0d of them with clamped or out-of-range fields.",
             dates_sent, odd_dates_sent);
    $display("Compared %0d Gregorian dates and weekdays against the prediction.", checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("shamsi_to_gregorian_weekday_core_test: clean");
    end else begin
      $display("shamsi_to_gregorian_weekday_core_test: errors");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a quarter of this.
  initial begin
    #2000000;
    $display("shamsi_to_gregorian_weekday_core_test: errors");
    $finish;
  end

endmodule
